// ----- rtl/aspz_pkg.sv -----
// ----------------------------------------------------------------------------
// aspz_pkg
// Shared types and constants for the analog stick polar zoner.
// ----------------------------------------------------------------------------
package aspz_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MAG_W    = 15;
  localparam int unsigned ANGLE_W  = 15;
  localparam int unsigned ZONE_W   = 3;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned CORDIC_STEPS = 16;

  localparam logic [ANGLE_W-1:0] ANG180 = 15'd11520;
  localparam logic [ANGLE_W-1:0] ANG360 = 15'd23040;

  // word handed from the front part to the back part
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
  } sample_t;

  // CORDIC rotation angles, 1/16384 degree
  function automatic logic [19:0] atan_step(input logic [3:0] i);
    logic [19:0] v;
    unique case (i)
      4'd0:  v = 20'd737280;
      4'd1:  v = 20'd435242;
      4'd2:  v = 20'd229970;
      4'd3:  v = 20'd116736;
      4'd4:  v = 20'd58595;
      4'd5:  v = 20'd29326;
      4'd6:  v = 20'd14667;
      4'd7:  v = 20'd7334;
      4'd8:  v = 20'd3667;
      4'd9:  v = 20'd1833;
      4'd10: v = 20'd917;
      4'd11: v = 20'd458;
      4'd12: v = 20'd229;
      4'd13: v = 20'd115;
      4'd14: v = 20'd57;
      default: v = 20'd29;
    endcase
    return v;
  endfunction

  function automatic logic [MAG_W-1:0] limit_reset(input int unsigned k);
    logic [MAG_W-1:0] v;
    unique case (k)
      0: v = 15'd1966;
      1: v = 15'd3277;
      2: v = 15'd8192;
      3: v = 15'd12288;
      default: v = 15'd16384;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/aspz_front.sv -----
// ----------------------------------------------------------------------------
// aspz_front
// Accept samples, apply the lock and queue them for the back part.
// ----------------------------------------------------------------------------
module aspz_front #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic signed [aspz_pkg::SAMPLE_W-1:0]   stick_x,
  input  logic signed [aspz_pkg::SAMPLE_W-1:0]   stick_y,
  input  logic                                   lock,
  output logic                                   q_valid,
  input  logic                                   q_take,
  output aspz_pkg::sample_t                      q_word
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  aspz_pkg::sample_t mem [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] cnt;
  logic          do_push;
  logic          do_pop;
  aspz_pkg::sample_t in_word;

  assign full    = (cnt == CW'(DEPTH));
  assign q_valid = (cnt != '0);
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;
  assign q_word  = mem[rp];

  // force zero deflection under lock
  always_comb begin
    in_word.x = lock ? '0 : stick_x;
    in_word.y = lock ? '0 : stick_y;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= in_word;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + CW'(do_push) - CW'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !q_valid == 1'b0) else $error("full but queue empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> cnt == $past(cnt) + 1'b1) else $error("count slip");
  a_pop_step: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> cnt == $past(cnt) - 1'b1) else $error("pop slip");

endmodule

// ----- rtl/aspz_back.sv -----
// ----------------------------------------------------------------------------
// aspz_back
// Sequencer: square root, CORDIC angle, zone search, fraction divide.
// ----------------------------------------------------------------------------
module aspz_back #(
  parameter int unsigned NUM_ZONES   = 5,
  parameter int unsigned FRAC_BITS   = 14,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_valid,
  output logic                                   q_take,
  input  aspz_pkg::sample_t                      q_word,
  input  logic [NUM_ZONES-1:0][aspz_pkg::MAG_W-1:0] limits,
  input  logic                                   pop,
  output logic                                   empty,
  output logic signed [aspz_pkg::SAMPLE_W-1:0]   used_x,
  output logic signed [aspz_pkg::SAMPLE_W-1:0]   used_y,
  output logic [aspz_pkg::MAG_W-1:0]             magnitude,
  output logic [aspz_pkg::ANGLE_W-1:0]           angle,
  output logic [aspz_pkg::ZONE_W-1:0]            zone,
  output logic [aspz_pkg::MAG_W-1:0]             zone_fraction,
  output logic [COUNT_WIDTH-1:0]                 moved_frames,
  output logic [COUNT_WIDTH-1:0]                 still_frames,
  output logic                                   move_started,
  output logic                                   move_stopped
);

  localparam int unsigned MW  = aspz_pkg::MAG_W;
  localparam int unsigned ZW  = aspz_pkg::ZONE_W;
  localparam int unsigned AW  = aspz_pkg::ANGLE_W;
  localparam int unsigned SW  = 32;   // sum of squares width
  localparam int unsigned RW  = 17;   // root width
  localparam int unsigned CDW = 28;   // CORDIC datapath
  localparam int unsigned ZDW = 24;   // CORDIC angle
  localparam int unsigned NW  = MW + FRAC_BITS + 1;
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
  localparam logic [FRAC_BITS+1:0] ONE_Q = (FRAC_BITS+2)'(1) << FRAC_BITS;
  localparam logic signed [ZDW-1:0] DEG90  = 24'sd1474560;
  localparam logic signed [ZDW-1:0] DEG180 = 24'sd2949120;

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_ROOT, S_RND, S_CORD, S_ANG, S_ZONE, S_DIV, S_OUT
  } state_t;

  state_t state;
  logic signed [15:0] x, y;
  logic [SW-1:0] sq_acc, rem;
  logic [SW-1:0] root;
  logic [4:0]    step;
  logic signed [CDW-1:0] cx, cy;
  logic signed [ZDW-1:0] cz;
  logic [AW-1:0] last_angle;
  logic [ZW-1:0] last_zone;
  logic [MW-1:0] last_fraction;
  logic [COUNT_WIDTH-1:0] moved_count, still_count;
  logic [RW-1:0] m;
  logic [ZW-1:0] zk;
  logic [NW-1:0] num, quo;
  logic [MW-1:0] den;
  logic [$clog2(NW+1)-1:0] dstep;
  logic signed [16:0] mul_a;
  logic [33:0] mul_p;

  // root bit trial and remainder
  logic [SW+1:0] trial;
  logic [SW-1:0] rbit;
  logic signed [CDW-1:0] dx, dy;
  logic [NW:0] rem_sh;
  logic [NW-1:0] drem;
  logic [MW-1:0] lo, hi;
  logic [ZDW-1:0] zc;
  logic [AW-1:0] a0, a1, a2;

  assign rbit  = SW'(1) << {step[3:0], 1'b0};
  assign trial = (SW+2)'(root) + (SW+2)'(rbit);
  assign dx    = cy >>> step[3:0];
  assign dy    = cx >>> step[3:0];
  assign mul_a = (state == S_SQX) ? 17'(x) : 17'(y);
  assign mul_p = 34'(mul_a * mul_a);
  assign lo    = limits[zk - 1'b1];
  assign hi    = limits[zk];
  assign rem_sh = {drem, num[NW-1]};

  // clamp and round the CORDIC angle, then fold into quadrant
  always_comb begin
    if (cz < 0) begin
      zc = '0;
    end else if (cz > DEG180) begin
      zc = DEG180;
    end else begin
      zc = cz;
    end
    a0 = AW'((ZDW+1)'(zc) + 25'd128 >> 8);
    a1 = x[15] ? aspz_pkg::ANG180 - a0 : a0;
    a2 = y[15] ? aspz_pkg::ANG360 - a1 : a1;
  end

  assign q_take = (state == S_IDLE) && empty;

  // run one sample at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      empty         <= 1'b1;
      last_angle    <= '0;
      last_zone     <= '0;
      last_fraction <= '0;
      moved_count   <= '0;
      still_count   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!empty && pop) begin
            empty <= 1'b1;
          end
          if (q_valid && empty) begin
            x     <= q_word.x;
            y     <= q_word.y;
            state <= S_SQX;
          end
        end
        S_SQX: begin
          sq_acc <= SW'(mul_p);
          state  <= S_SQY;
        end
        S_SQY: begin
          rem   <= sq_acc + SW'(mul_p);
          root  <= '0;
          step  <= 5'd15;
          state <= S_ROOT;
        end
        S_ROOT: begin
          // one result bit per cycle
          if ((SW+2)'(rem) >= trial) begin
            rem  <= rem - SW'(trial);
            root <= (root >> 1) + rbit;
          end else begin
            root <= root >> 1;
          end
          if (step == 5'd0) begin
            state <= S_RND;
          end else begin
            step <= step - 1'b1;
          end
        end
        S_RND: begin
          m <= RW'((rem > root) ? root + 1'b1 : root);
          if (x == 0 && y == 0) begin
            moved_count <= '0;
            if (still_count != CMAX) begin
              still_count <= still_count + 1'b1;
            end
            state <= S_ZONE;
          end else begin
            still_count <= '0;
            if (moved_count != CMAX) begin
              moved_count <= moved_count + 1'b1;
            end
            // CORDIC on (y, |x|) with a quarter turn when y < 0
            if (y[15]) begin
              cx <= CDW'(x[15] ? -32'(x) : 32'(x)) <<< 8;
              cy <= -(CDW'(y) <<< 8);
              cz <= DEG90;
            end else begin
              cx <= CDW'(y) <<< 8;
              cy <= CDW'(x[15] ? -32'(x) : 32'(x)) <<< 8;
              cz <= '0;
            end
            step  <= '0;
            state <= S_CORD;
          end
        end
        S_CORD: begin
          if (cy >= 0) begin
            cx <= cx + dx;
            cy <= cy - dy;
            cz <= cz + ZDW'(aspz_pkg::atan_step(step[3:0]));
          end else begin
            cx <= cx - dx;
            cy <= cy + dy;
            cz <= cz - ZDW'(aspz_pkg::atan_step(step[3:0]));
          end
          if (step == 5'd15) begin
            state <= S_ANG;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_ANG: begin
          last_angle <= a2;
          state      <= S_ZONE;
        end
        S_ZONE: begin
          // clamp once, then walk the limits one per cycle
          if (m > ONE_Q) begin
            m <= RW'(ONE_Q);
          end else if (m <= RW'(limits[0])) begin
            last_zone     <= '0;
            last_fraction <= '0;
            state         <= S_OUT;
          end else begin
            zk    <= ZW'(1);
            state <= S_DIV;
            dstep <= '0;
          end
        end
        S_DIV: begin
          if (dstep == '0) begin
            if (RW'(lo) < m && m <= RW'(hi)) begin
              num   <= NW'(m - RW'(lo)) << FRAC_BITS;
              den   <= hi - lo;
              drem  <= '0;
              quo   <= '0;
              dstep <= dstep + 1'b1;
            end else if (zk == ZW'(NUM_ZONES - 1)) begin
              state <= S_OUT;
            end else begin
              zk <= zk + 1'b1;
            end
          end else begin
            // restoring division, one quotient bit per cycle
            if (rem_sh >= (NW+1)'(den)) begin
              drem <= NW'(rem_sh - (NW+1)'(den));
              quo  <= {quo[NW-2:0], 1'b1};
            end else begin
              drem <= NW'(rem_sh);
              quo  <= {quo[NW-2:0], 1'b0};
            end
            num <= num << 1;
            if (dstep == ($bits(dstep))'(NW)) begin
              last_zone     <= zk;
              last_fraction <= MW'({quo[NW-2:0], (rem_sh >= (NW+1)'(den))});
              state <= S_OUT;
            end else begin
              dstep <= dstep + 1'b1;
            end
          end
        end
        S_OUT: begin
          used_x    <= x;
          used_y    <= y;
          magnitude <= MW'(m);
          empty     <= 1'b0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign angle         = last_angle;
  assign zone          = last_zone;
  assign zone_fraction = last_fraction;
  assign moved_frames  = moved_count;
  assign still_frames  = still_count;
  assign move_started  = (moved_count == COUNT_WIDTH'(1));
  assign move_stopped  = (still_count == COUNT_WIDTH'(1));

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    q_take |-> empty) else $error("took word while result pending");
  a_counters: assert property (@(posedge clk) disable iff (rst)
    !(moved_count != '0 && still_count != '0)) else $error("both counters live");
  a_zone_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, last_zone} < (ZW+1)'(NUM_ZONES)) else $error("zone out of range");

endmodule

// ----- rtl/analog_stick_polar_zoner_core.sv -----
// ----------------------------------------------------------------------------
// analog_stick_polar_zoner_core
// Stick sample to magnitude, angle and magnitude zone, with frame counters.
//
//   channel   handshake           payload
//   input     push / full         stick_x, stick_y
//   result    empty / pop         used_x .. move_stopped
//   config    cfg_valid/cfg_ready cfg_index, cfg_data
//
// From accept to result a sample passes through the multiply, root and round
// steps, the CORDIC and fold steps for nonzero samples, a clamp above one,
// the limit checks, the divide steps and the result load. The front queue
// takes two samples while the back end works. Synchronous reset clears state
// and limits to their power-up values. A pending result stalls the back end
// until popped; the next sample is taken once the pop has set empty again.
// ----------------------------------------------------------------------------
module analog_stick_polar_zoner_core #(
  parameter int unsigned NUM_ZONES   = 5,
  parameter int unsigned FRAC_BITS   = 14,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [aspz_pkg::SAMPLE_W-1:0] stick_x,
  input  logic signed [aspz_pkg::SAMPLE_W-1:0] stick_y,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [aspz_pkg::SAMPLE_W-1:0] used_x,
  output logic signed [aspz_pkg::SAMPLE_W-1:0] used_y,
  output logic [aspz_pkg::MAG_W-1:0]           magnitude,
  output logic [aspz_pkg::ANGLE_W-1:0]         angle,
  output logic [aspz_pkg::ZONE_W-1:0]          zone,
  output logic [aspz_pkg::MAG_W-1:0]           zone_fraction,
  output logic [COUNT_WIDTH-1:0]               moved_frames,
  output logic [COUNT_WIDTH-1:0]               still_frames,
  output logic                                 move_started,
  output logic                                 move_stopped,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [aspz_pkg::IDX_W-1:0]           cfg_index,
  input  logic [31:0]                          cfg_data
);

  logic [NUM_ZONES-1:0][aspz_pkg::MAG_W-1:0] limits;
  logic              lock;
  logic              q_valid;
  logic              q_take;
  aspz_pkg::sample_t q_word;

  assign cfg_ready = 1'b1;

  // register writes; indexes past the lock are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_ZONES; k++) begin
        limits[k] <= aspz_pkg::limit_reset(k);
      end
      lock <= 1'b0;
    end else if (cfg_valid) begin
      for (int k = 0; k < NUM_ZONES; k++) begin
        if (cfg_index == aspz_pkg::IDX_W'(k)) begin
          limits[k] <= cfg_data[aspz_pkg::MAG_W-1:0];
        end
      end
      if (cfg_index == aspz_pkg::IDX_W'(NUM_ZONES)) begin
        lock <= cfg_data[0];
      end
    end
  end

  aspz_front #(.DEPTH(2)) u_front (
    .clk, .rst, .push, .full, .stick_x, .stick_y, .lock,
    .q_valid, .q_take, .q_word
  );

  aspz_back #(
    .NUM_ZONES(NUM_ZONES), .FRAC_BITS(FRAC_BITS), .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk, .rst, .q_valid, .q_take, .q_word, .limits, .pop, .empty,
    .used_x, .used_y, .magnitude, .angle, .zone, .zone_fraction,
    .moved_frames, .still_frames, .move_started, .move_stopped
  );

endmodule

// ----- tb/analog_stick_polar_zoner_checker.sv -----
// ----------------------------------------------------------------------------
// analog_stick_polar_zoner_checker
// Watches the sample, config and result channels of the stick polar zoner,
// predicts every result word and compares it with the word that leaves.
// ----------------------------------------------------------------------------
module analog_stick_polar_zoner_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  input  logic                                 full,
  input  logic signed [aspz_pkg::SAMPLE_W-1:0] stick_x,
  input  logic signed [aspz_pkg::SAMPLE_W-1:0] stick_y,
  input  logic                                 empty,
  input  logic                                 pop,
  input  logic signed [aspz_pkg::SAMPLE_W-1:0] used_x,
  input  logic signed [aspz_pkg::SAMPLE_W-1:0] used_y,
  input  logic [aspz_pkg::MAG_W-1:0]           magnitude,
  input  logic [aspz_pkg::ANGLE_W-1:0]         angle,
  input  logic [aspz_pkg::ZONE_W-1:0]          zone,
  input  logic [aspz_pkg::MAG_W-1:0]           zone_fraction,
  input  logic [15:0]                          moved_frames,
  input  logic [15:0]                          still_frames,
  input  logic                                 move_started,
  input  logic                                 move_stopped,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [aspz_pkg::IDX_W-1:0]           cfg_index,
  input  logic [31:0]                          cfg_data,
  output int                                   errors,
  output int                                   pending
);

  localparam int ZONES     = 5;
  localparam int LOCK_IDX  = ZONES;
  localparam int ONE_Q     = 16384;
  localparam int CNT_MAX   = 65535;
  localparam longint DEG90  = 1474560;
  localparam longint DEG180 = 2949120;

  typedef struct packed {
    logic signed [aspz_pkg::SAMPLE_W-1:0] ux;
    logic signed [aspz_pkg::SAMPLE_W-1:0] uy;
    logic [aspz_pkg::MAG_W-1:0]           mag;
    logic [aspz_pkg::ANGLE_W-1:0]         ang;
    logic [aspz_pkg::ZONE_W-1:0]          zn;
    logic [aspz_pkg::MAG_W-1:0]           frac;
    logic [15:0]                          moved;
    logic [15:0]                          still;
    logic                                 started;
    logic                                 stopped;
  } polar_word_t;

  polar_word_t polar_q[$];

  // predictor state
  int unsigned limit_r[ZONES];
  bit          lock_r;
  int unsigned hold_angle, hold_zone, hold_frac, moved_cnt, still_cnt;

  function automatic longint unsigned round_root(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (s > r) r++;
    return r;
  endfunction

  // vectoring CORDIC, result in 1/64 degree, 0..180 degrees
  function automatic int unsigned half_turn_angle(longint bx, longint ay);
    longint steps[16] = '{737280, 435242, 229970, 116736, 58595, 29326, 14667,
                          7334, 3667, 1833, 917, 458, 229, 115, 57, 29};
    longint cx, cy, z, t, dx, dy;
    cx = bx * 256;
    cy = ay * 256;
    z  = 0;
    if (cx < 0) begin
      t  = cx;
      cx = cy;
      cy = -t;
      z  = DEG90;
    end
    for (int i = 0; i < 16; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; z += steps[i];
      end else begin
        cx -= dx; cy += dy; z -= steps[i];
      end
    end
    if (z < 0) z = 0;
    if (z > DEG180) z = DEG180;
    return int'((z + 128) >>> 8);
  endfunction

  function automatic polar_word_t predict_polar(logic signed [15:0] sx,
                                                logic signed [15:0] sy);
    polar_word_t w;
    longint x, y, ax;
    longint unsigned s, m, lo, hi;
    int unsigned a;
    x = lock_r ? 0 : longint'(sx);
    y = lock_r ? 0 : longint'(sy);
    s = longint'(x * x + y * y);
    m = round_root(s);
    if (s != 0) begin
      ax = x < 0 ? -x : x;
      a  = half_turn_angle(y, ax);
      still_cnt = 0;
      if (moved_cnt < CNT_MAX) moved_cnt++;
      if (x < 0) a = int'(aspz_pkg::ANG180) - a;
      if (y < 0) a = int'(aspz_pkg::ANG360) - a;
      hold_angle = a;
    end else begin
      moved_cnt = 0;
      if (still_cnt < CNT_MAX) still_cnt++;
    end
    if (m > ONE_Q) m = ONE_Q;
    // pick the zone; no match keeps the previous zone
    if (m <= limit_r[0]) begin
      hold_zone = 0;
      hold_frac = 0;
    end else begin
      for (int k = 1; k < ZONES; k++) begin
        lo = limit_r[k-1];
        hi = limit_r[k];
        if (lo < m && m <= hi) begin
          hold_zone = k;
          hold_frac = int'(((m - lo) << 14) / (hi - lo));
          break;
        end
      end
    end
    w.ux      = x[15:0];
    w.uy      = y[15:0];
    w.mag     = m[14:0];
    w.ang     = hold_angle[14:0];
    w.zn      = hold_zone[2:0];
    w.frac    = hold_frac[14:0];
    w.moved   = moved_cnt[15:0];
    w.still   = still_cnt[15:0];
    w.started = moved_cnt == 1;
    w.stopped = still_cnt == 1;
    return w;
  endfunction

  polar_word_t seen_w, want_w;

  always_comb begin
    seen_w = '{used_x, used_y, magnitude, angle, zone, zone_fraction,
               moved_frames, still_frames, move_started, move_stopped};
  end

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ZONES; k++) limit_r[k] = aspz_pkg::limit_reset(k);
      lock_r     = 0;
      hold_angle = 0;
      hold_zone  = 0;
      hold_frac  = 0;
      moved_cnt  = 0;
      still_cnt  = 0;
      errors     = 0;
      polar_q.delete();
      pending    = 0;
    end else begin
      // apply register writes; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < ZONES) limit_r[cfg_index] = cfg_data[14:0];
        else if (cfg_index == LOCK_IDX) lock_r = cfg_data[0];
      end
      if (push && !full) polar_q.push_back(predict_polar(stick_x, stick_y));
      // compare the word that leaves with the oldest prediction
      if (pop && !empty) begin
        if (polar_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %p", seen_w);
        end else begin
          want_w = polar_q.pop_front();
          if (want_w != seen_w) begin
            errors++;
            if (errors <= 10)
              $display("result mismatch\n  exp %p\n  act %p", want_w, seen_w);
          end
        end
      end
      pending = polar_q.size();
    end
  end

endmodule

// ----- tb/tb_analog_stick_polar_zoner_core.sv -----
// ----------------------------------------------------------------------------
// tb_analog_stick_polar_zoner_core
// Drives directed and random stick samples and register settings through the
// polar zoner under varying idle and stall patterns; the checker judges.
// ----------------------------------------------------------------------------
module tb_analog_stick_polar_zoner_core;

  localparam int LOCK_IDX = 5;

  logic clk, rst, push, full, empty, pop, cfg_valid, cfg_ready;
  logic signed [15:0] stick_x, stick_y, used_x, used_y;
  logic [14:0] magnitude, angle, zone_fraction;
  logic [2:0]  zone;
  logic [15:0] moved_frames, still_frames;
  logic        move_started, move_stopped;
  logic [3:0]  cfg_index;
  logic [31:0] cfg_data;
  int          errors, pending;

  int idle_mode;
  bit hold_req, hold_done;
  int hold_left;

  analog_stick_polar_zoner_core dut (.*);
  analog_stick_polar_zoner_checker chk (.*);

  // clock
  initial clk = 0;
  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // limit on the whole run
  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic bit tx_gap();
    if (idle_mode == 1) return $urandom_range(99) < 45;
    if (idle_mode == 3) return $urandom_range(99) < 37;
    return 0;
  endfunction

  // result side: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      pop <= 0;
    end else if (hold_req && !hold_done) begin
      hold_left = 400;
      hold_done = 1;
      pop <= 0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 0;
    end else if (idle_mode == 2) begin
      pop <= $urandom_range(99) >= 45;
    end else if (idle_mode == 3) begin
      pop <= $urandom_range(99) >= 37;
    end else begin
      pop <= 1;
    end
  end

  task automatic write_reg(input int idx, input logic [31:0] val);
    cfg_valid = 1;
    cfg_index = idx[3:0];
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic send_sample(input logic signed [15:0] sx, input logic signed [15:0] sy);
    while (tx_gap()) begin
      push = 0;
      @(negedge clk);
    end
    push    = 1;
    stick_x = sx;
    stick_y = sy;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // hold until the block is drained before touching registers
  task automatic drain();
    push = 0;
    wait (pending == 0);
    repeat (100) @(negedge clk);
  endtask

  task automatic set_limits(input int l0, l1, l2, l3, l4, input bit lk);
    write_reg(0, 32'(15'(l0)) | ($urandom & 32'hFFFF8000));
    write_reg(1, 32'(l1) | ($urandom & 32'hFFFF8000));
    write_reg(2, 32'(l2));
    write_reg(3, 32'(l3));
    write_reg(4, 32'(l4));
    write_reg(LOCK_IDX, {$urandom_range(1) ? 31'h7FFFFFFF : 31'h0, lk});
    write_reg($urandom_range(15, 6), $urandom);
  endtask

  function automatic logic signed [15:0] rand_deflect();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 16'($urandom_range(32768) - 16384);
    if (r < 70) return 16'($urandom_range(400) - 200);
    if (r < 80) return '0;
    if (r < 90) return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
    return 16'($urandom);
  endfunction

  int lim[5];

  initial begin
    rst = 1;
    push = 0;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    stick_x = 0;
    stick_y = 0;
    idle_mode = 0;
    hold_req = 0;
    hold_done = 0;
    hold_left = 0;
    repeat (11) @(negedge clk);
    rst = 0;

    // directed: zero first, axes, diagonals, field extremes, tiny moves
    send_sample(0, 0);
    send_sample(0, 0);
    send_sample(16384, 0);
    send_sample(0, 16384);
    send_sample(-16384, 0);
    send_sample(0, -16384);
    send_sample(-16384, -16384);
    send_sample(16384, -16384);
    send_sample(32767, 32767);
    send_sample(-32768, -32768);
    send_sample(-32768, 32767);
    send_sample(1, 0);
    send_sample(0, -1);
    send_sample(-1, 1);
    send_sample(100, 100);
    send_sample(0, 0);
    send_sample(5000, -3000);
    drain();
    // lock forces zero; limits with a low top make zone and fraction hold
    set_limits(1000, 2000, 3000, 4000, 10000, 1);
    send_sample(12000, 7000);
    send_sample(-9000, 300);
    drain();
    set_limits(1000, 2000, 3000, 4000, 10000, 0);
    send_sample(3500, 0);
    send_sample(16384, 16384);
    send_sample(0, 2500);
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 8; ph++) begin
      idle_mode = ph % 4;
      case (ph)
        0: set_limits(1966, 3277, 8192, 12288, 16384, 0);
        1: set_limits(0, 0, 0, 0, 0, 0);
        2: set_limits(16384, 16384, 16384, 16384, 16384, 0);
        3: set_limits(0, 4096, 8192, 12288, 16384, $urandom_range(1));
        4: set_limits($urandom_range(32767), $urandom_range(32767), $urandom_range(16384),
                      $urandom_range(16384), $urandom_range(16384), 0);
        default: begin
          foreach (lim[k]) lim[k] = $urandom_range(16384);
          lim.sort();
          set_limits(lim[0], lim[1], lim[2], lim[3], lim[4], 0);
        end
      endcase
      if (ph == 2) hold_req = 1;
      for (int n = 0; n < 100; n++) send_sample(rand_deflect(), rand_deflect());
      // pause until everything is back, then keep going
      if (ph == 4) begin
        push = 0;
        wait (pending == 0);
        @(negedge clk);
      end
      drain();
    end

    push = 0;
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
